[src/imufp_pkg.sv]
// Shared types, constants and the scaling function of the IMU frame parser.
`default_nettype none
package imufp_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES_DEF = 11;
  localparam int unsigned DATA_LAST       = 7;   // last frame byte that carries data
  localparam logic [7:0]  HDR_BYTE        = 8'h55;
  localparam logic [7:0]  TYPE_ACCEL      = 8'h51;
  localparam logic [7:0]  TYPE_GYRO       = 8'h52;

  // Field widths
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned OUT_W       = 17;
  localparam int unsigned SCALE_SHIFT = 15;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 2'd1;
  localparam logic [SCALE_W-1:0]   ACCEL_SCALE_RST = 16'd40141;
  localparam logic [SCALE_W-1:0]   GYRO_SCALE_RST  = 16'd35744;

  // Queue depths
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH       = 2;

  // One raw sample set handed from the front to the back
  typedef struct packed {
    logic [2:0][RAW_W-1:0] accel;
    logic [2:0][RAW_W-1:0] rate;
  } raw_set_t;

  // One scaled result word
  typedef struct packed {
    logic [2:0][OUT_W-1:0] accel;
    logic [2:0][OUT_W-1:0] rate;
  } sample_t;

  // floor(raw * scale / 2^15): signed raw, unsigned scale, exact in 17 bits
  function automatic logic [OUT_W-1:0] scale_value(input logic [RAW_W-1:0] raw,
                                                   input logic [SCALE_W-1:0] scl);
    logic signed [RAW_W:0]           raw_ext;
    logic signed [SCALE_W:0]         scl_ext;
    logic signed [RAW_W+SCALE_W+1:0] prod;
    raw_ext = $signed({raw[RAW_W-1], raw});
    scl_ext = $signed({1'b0, scl});
    prod    = raw_ext * scl_ext;
    return prod[SCALE_SHIFT+OUT_W-1:SCALE_SHIFT];
  endfunction

endpackage
`default_nettype wire

[src/imufp_fifo.sv]
// Small register-based queue used between the parser stages and at the output.
`default_nettype none
module imufp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[src/imufp_front.sv]
// Front end: header hunt, frame capture, type decode, sample holds and pairing.
`default_nettype none
module imufp_front #(
  parameter int unsigned FRAME_BYTES = imufp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_vld_i,
  input  wire logic [7:0]    byte_i,
  output logic               set_vld_o,
  output imufp_pkg::raw_set_t set_o
);
  import imufp_pkg::*;

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);

  logic [POS_W-1:0]     pos_q, pos_d;
  logic [7:0]           store_q [DATA_LAST:1];
  logic [7:0]           view    [DATA_LAST:1];
  logic [2:0][RAW_W-1:0] accel_q, accel_d, rate_q, rate_d;
  logic                 accel_seen_q, accel_seen_d, rate_seen_q, rate_seen_d;
  logic                 frame_done;

  // frame bytes as seen this cycle, the incoming byte included
  always_comb begin
    for (int i = 1; i <= DATA_LAST; i++) begin
      view[i] = (pos_q == POS_W'(i)) ? byte_i : store_q[i];
    end
  end

  // position counter: zero while hunting for the header
  always_comb begin
    pos_d      = pos_q;
    frame_done = 1'b0;
    if (byte_vld_i) begin
      if (pos_q == '0) begin
        if (byte_i == HDR_BYTE) begin
          pos_d = POS_W'(1);
        end
      end else if (pos_q == POS_W'(FRAME_BYTES - 1)) begin
        pos_d      = '0;
        frame_done = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // holds, marks and pairing of accel and gyro sets
  always_comb begin
    accel_d      = accel_q;
    rate_d       = rate_q;
    accel_seen_d = accel_seen_q;
    rate_seen_d  = rate_seen_q;
    set_vld_o    = 1'b0;
    if (frame_done) begin
      case (view[1])
        TYPE_ACCEL: begin
          for (int k = 0; k < 3; k++) begin
            accel_d[k] = {view[3 + 2*k], view[2 + 2*k]};
          end
          accel_seen_d = 1'b1;
        end
        TYPE_GYRO: begin
          for (int k = 0; k < 3; k++) begin
            rate_d[k] = {view[3 + 2*k], view[2 + 2*k]};
          end
          rate_seen_d = 1'b1;
        end
        default: ;
      endcase
      if (accel_seen_d && rate_seen_d) begin
        set_vld_o    = 1'b1;
        accel_seen_d = 1'b0;
        rate_seen_d  = 1'b0;
      end
    end
  end

  assign set_o.accel = accel_d;
  assign set_o.rate  = rate_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      accel_q      <= '0;
      rate_q       <= '0;
      accel_seen_q <= 1'b0;
      rate_seen_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      accel_q      <= accel_d;
      rate_q       <= rate_d;
      accel_seen_q <= accel_seen_d;
      rate_seen_q  <= rate_seen_d;
    end
  end

  // frame byte capture, only the type and data bytes are kept
  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= DATA_LAST; i++) begin
      if (byte_vld_i && pos_q == POS_W'(i)) begin
        store_q[i] <= byte_i;
      end
    end
  end

endmodule
`default_nettype wire

[src/imufp_back.sv]
// Back end: scale registers, six scaling lanes and the result queue.
`default_nettype none
module imufp_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic [imufp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [imufp_pkg::SCALE_W-1:0]      cfg_data_i,
  input  wire logic                               set_vld_i,
  input  wire imufp_pkg::raw_set_t                set_i,
  output logic                                    set_pop_o,
  input  wire logic                               pop_i,
  output logic                                    empty_o,
  output imufp_pkg::sample_t                      sample_o
);
  import imufp_pkg::*;

  logic [SCALE_W-1:0] accel_scale_q, gyro_scale_q;
  sample_t            scaled;
  logic               out_full;
  logic [$bits(sample_t)-1:0] out_rdata;

  // scale registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_scale_q <= ACCEL_SCALE_RST;
      gyro_scale_q  <= GYRO_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ACCEL_SCALE: accel_scale_q <= cfg_data_i;
        REG_GYRO_SCALE:  gyro_scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one multiplier per lane, queue head to result queue
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      scaled.accel[k] = scale_value(set_i.accel[k], accel_scale_q);
      scaled.rate[k]  = scale_value(set_i.rate[k], gyro_scale_q);
    end
  end

  assign set_pop_o = set_vld_i && !out_full;

  imufp_fifo #(
    .WIDTH($bits(sample_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (set_pop_o),
    .wdata_i(scaled),
    .full_o (out_full),
    .pop_i  (pop_i),
    .rdata_o(out_rdata),
    .empty_o(empty_o)
  );

  assign sample_o = out_rdata;

endmodule
`default_nettype wire

[src/imu_serial_frame_parser.sv]
// Top level of the IMU serial frame parser: front end, set queue and back end.
//
//   channel  direction  handshake             word
//   input    in         push / full           rx_byte_i
//   result   out        empty / pop           accel_{x,y,z}_o, rate_{x,y,z}_o
//   config   in         cfg_valid / cfg_ready cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while full is low; the front end decodes it in that cycle.
// A completed pair of sets enters the set queue at the edge that takes its
// last byte, moves to the result queue once it heads the set queue and there
// is room, and shows on the result ports once it heads the result queue.
// full follows the set queue only; result stalls back up through it.
// Reset clears the position, the holds, the marks and both queues; cfg_ready is
// always high.
`default_nettype none
module imu_serial_frame_parser #(
  parameter int unsigned FRAME_BYTES = imufp_pkg::FRAME_BYTES_DEF,
  parameter int unsigned Q_DEPTH     = imufp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      rx_byte_i,
  input  wire logic                            pop,
  output logic                                 empty,
  output logic [imufp_pkg::OUT_W-1:0]          accel_x_o,
  output logic [imufp_pkg::OUT_W-1:0]          accel_y_o,
  output logic [imufp_pkg::OUT_W-1:0]          accel_z_o,
  output logic [imufp_pkg::OUT_W-1:0]          rate_x_o,
  output logic [imufp_pkg::OUT_W-1:0]          rate_y_o,
  output logic [imufp_pkg::OUT_W-1:0]          rate_z_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [imufp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [imufp_pkg::SCALE_W-1:0]   cfg_data_i
);
  import imufp_pkg::*;

  logic     byte_vld;
  logic     front_vld;
  raw_set_t front_set;
  logic     q_empty, q_pop;
  logic [$bits(raw_set_t)-1:0] q_rdata;
  raw_set_t q_set;
  sample_t  sample;

  assign byte_vld    = push && !full;
  assign cfg_ready_o = 1'b1;

  imufp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_vld_i(byte_vld),
    .byte_i    (rx_byte_i),
    .set_vld_o (front_vld),
    .set_o     (front_set)
  );

  // decoupling queue between decode and scaling
  imufp_fifo #(
    .WIDTH($bits(raw_set_t)),
    .DEPTH(Q_DEPTH)
  ) u_set_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld),
    .wdata_i(front_set),
    .full_o (full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign q_set = q_rdata;

  imufp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .set_vld_i  (!q_empty),
    .set_i      (q_set),
    .set_pop_o  (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .sample_o   (sample)
  );

  assign accel_x_o = sample.accel[0];
  assign accel_y_o = sample.accel[1];
  assign accel_z_o = sample.accel[2];
  assign rate_x_o  = sample.rate[0];
  assign rate_y_o  = sample.rate[1];
  assign rate_z_o  = sample.rate[2];

endmodule
`default_nettype wire

[dv/tb_imu_serial_frame_parser.sv]
// Self-checking testbench for the IMU serial frame parser top level.
`timescale 1ns / 100ps
module tb_imu_serial_frame_parser;
  import imufp_pkg::*;

  localparam int unsigned WDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int unsigned SETTLE     = 8;     // negedges waited after the last expected sample is back
  localparam int unsigned PHASE_LEN  = 280;   // random bytes per scale setting
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  // DUT pins
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [7:0]           rx_byte_i   = '0;
  logic                 pop         = 1'b0;
  logic                 empty;
  logic [OUT_W-1:0]     accel_x_o, accel_y_o, accel_z_o;
  logic [OUT_W-1:0]     rate_x_o, rate_y_o, rate_z_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SCALE_W-1:0]   cfg_data_i  = '0;

  // Stimulus and expectation stores
  logic [7:0] pending_bytes [$];
  sample_t    sample_q [$];

  // Idling percentages, changed between phases on the falling edge
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Bookkeeping
  int unsigned errors        = 0;
  int unsigned bytes_taken   = 0;
  int unsigned samples_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned idle_cycles   = 0;

  // Parser shadow state, reset values
  logic [3:0]       pos_q = '0;
  logic [7:0]       frm_q [16];
  logic [RAW_W-1:0] acc_raw [3] = '{default: '0};
  logic [RAW_W-1:0] gyr_raw [3] = '{default: '0};
  logic             acc_held = 1'b0;
  logic             gyr_held = 1'b0;
  logic [SCALE_W-1:0] acc_scl = ACCEL_SCALE_RST;
  logic [SCALE_W-1:0] gyr_scl = GYRO_SCALE_RST;

  imu_serial_frame_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .pop         (pop),
    .empty       (empty),
    .accel_x_o   (accel_x_o),
    .accel_y_o   (accel_y_o),
    .accel_z_o   (accel_z_o),
    .rate_x_o    (rate_x_o),
    .rate_y_o    (rate_y_o),
    .rate_z_o    (rate_z_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // floor(raw * scale / 2^15), raw signed, scale unsigned
  function automatic logic [OUT_W-1:0] fixed_scale(input logic [RAW_W-1:0] raw,
                                                   input logic [SCALE_W-1:0] scl);
    longint p;
    p = longint'($signed(raw)) * longint'(scl);
    p = p >>> SCALE_SHIFT;
    return p[OUT_W-1:0];
  endfunction

  // Append one byte to the stimulus queue
  task automatic queue_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endtask

  // Advance the shadow parser by one byte; queue a sample when a pair completes
  task automatic parse_byte(input logic [7:0] b);
    sample_t s;
    if (pos_q == 0) begin
      if (b == HDR_BYTE) begin
        frm_q[0] = b;
        pos_q    = 4'd1;
      end
      return;
    end
    frm_q[pos_q] = b;
    pos_q = pos_q + 4'd1;
    if (pos_q != 0 && pos_q < FRAME_BYTES_DEF) return;
    pos_q = '0;
    if (frm_q[1] == TYPE_ACCEL) begin
      for (int k = 0; k < 3; k++) acc_raw[k] = {frm_q[3 + 2*k], frm_q[2 + 2*k]};
      acc_held = 1'b1;
    end else if (frm_q[1] == TYPE_GYRO) begin
      for (int k = 0; k < 3; k++) gyr_raw[k] = {frm_q[3 + 2*k], frm_q[2 + 2*k]};
      gyr_held = 1'b1;
    end else begin
      return;
    end
    if (!(acc_held && gyr_held)) return;
    for (int k = 0; k < 3; k++) begin
      s.accel[k] = fixed_scale(acc_raw[k], acc_scl);
      s.rate[k]  = fixed_scale(gyr_raw[k], gyr_scl);
    end
    acc_held = 1'b0;
    gyr_held = 1'b0;
    sample_q = {sample_q, s};
  endtask

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%t  %s", $realtime, msg);
  endtask

  // Compare the word on the result ports with the oldest expected sample
  task automatic check_sample();
    sample_t want, got;
    string   names [6];
    names = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z"};
    got.accel[0] = accel_x_o;
    got.accel[1] = accel_y_o;
    got.accel[2] = accel_z_o;
    got.rate[0]  = rate_x_o;
    got.rate[1]  = rate_y_o;
    got.rate[2]  = rate_z_o;
    samples_seen++;
    if (sample_q.size() == 0) begin
      flag($sformatf("unexpected sample word %h", got));
      return;
    end
    want = sample_q.pop_front();
    for (int k = 0; k < 3; k++) begin
      if (got.accel[k] !== want.accel[k])
        flag($sformatf("%s: expected %h, got %h", names[k], want.accel[k], got.accel[k]));
      if (got.rate[k] !== want.rate[k])
        flag($sformatf("%s: expected %h, got %h", names[3+k], want.rate[k], got.rate[k]));
    end
  endtask

  // Byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      rx_byte_i <= '0;
    end else begin
      if (push && !full) begin
        parse_byte(rx_byte_i);
        bytes_taken++;
      end
      if (push && full) begin
        // hold the word until taken
      end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push      <= 1'b1;
        rx_byte_i <= pending_bytes.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Sample monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_sample();
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAIL imu_serial_frame_parser");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_frame(input logic [7:0] kind, input logic [RAW_W-1:0] w0,
                           input logic [RAW_W-1:0] w1, input logic [RAW_W-1:0] w2);
    queue_byte(HDR_BYTE);
    queue_byte(kind);
    queue_byte(w0[7:0]);
    queue_byte(w0[15:8]);
    queue_byte(w1[7:0]);
    queue_byte(w1[15:8]);
    queue_byte(w2[7:0]);
    queue_byte(w2[15:8]);
    // checksum and trailing bytes, all ignored
    for (int k = DATA_LAST + 1; k < FRAME_BYTES_DEF; k++)
      queue_byte(8'($urandom));
  endtask

  // Raw word biased toward the range ends
  function automatic logic [RAW_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly good frames, with foreign types, noise, cut-short frames and 0x55-rich data
  task automatic gen_traffic(input int unsigned n);
    int unsigned start, r;
    logic [7:0]  kind;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n) begin
      r    = $urandom_range(0, 99);
      kind = $urandom_range(0, 1) ? TYPE_ACCEL : TYPE_GYRO;
      if (r < 62) begin
        add_frame(kind, pick_word(), pick_word(), pick_word());
      end else if (r < 72) begin
        add_frame(8'($urandom), pick_word(), pick_word(), pick_word());
      end else if (r < 82) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else if (r < 90) begin
        queue_byte(HDR_BYTE);
        queue_byte(kind);
        repeat ($urandom_range(0, 7)) queue_byte(8'($urandom));
      end else begin
        add_frame(kind, {HDR_BYTE, 8'($urandom)}, {HDR_BYTE, HDR_BYTE}, pick_word());
      end
    end
  endtask

  // Register write through the config channel; shadow follows on handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_ACCEL_SCALE: acc_scl = val;
      REG_GYRO_SCALE:  gyr_scl = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Wait for every byte to be taken and every sample to come back
  task automatic wait_idle();
    do @(negedge clk_i); while (pending_bytes.size() != 0 || push || sample_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [SCALE_W-1:0] a_scl, input logic [SCALE_W-1:0] g_scl,
                           input int unsigned s_pct, input int unsigned r_pct);
    write_reg(REG_ACCEL_SCALE, a_scl);
    write_reg(REG_GYRO_SCALE, g_scl);
    @(negedge clk_i);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    gen_traffic(PHASE_LEN);
    wait_idle();
  endtask

  // Sequencer
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: dropped noise, range-end values, header value inside a frame
    queue_byte(8'h00);
    queue_byte(8'hFF);
    add_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, {HDR_BYTE, HDR_BYTE});
    add_frame(TYPE_GYRO, 16'hFFFF, 16'h0000, 16'h8000);
    gen_traffic(PHASE_LEN);
    wait_idle();

    write_reg(REG_UNUSED_A, 16'($urandom));
    run_phase(16'hFFFF, 16'h0000, 71, 0);
    run_phase(16'h0000, 16'hFFFF, 0, 71);
    run_phase(16'($urandom), 16'($urandom), 26, 26);
    write_reg(REG_UNUSED_B, 16'($urandom));
    run_phase(16'h0001, 16'hFFFF, 0, 0);
    run_phase(16'($urandom), 16'($urandom), 71, 0);
    run_phase(16'hFFFF, 16'hFFFF, 0, 71);

    // nothing may be left waiting once every expected sample is back
    if (!empty) flag("result word left over after the last expected sample");

    $display("Covered %0d serial bytes under seven scale settings, %0d samples compared.",
             bytes_taken, samples_seen);
    $display("Config writes: %0d, out-of-range indexes included; mismatches: %0d.",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("PASS imu_serial_frame_parser");
    end else begin
      $display("FAIL imu_serial_frame_parser");
    end
    $finish;
  end

endmodule
